// ===== rtl/pulse_flow_meter_unit_defines.svh =====
// Assertion macros shared by the pulse flow meter RTL.
`ifndef PULSE_FLOW_METER_UNIT_DEFINES_SVH
`define PULSE_FLOW_METER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define PFM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pulse_flow_meter: property violated");
// Property checked on every clock edge, reset included.
`define PFM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("pulse_flow_meter: property violated");
`else
`define PFM_ASSERT(lbl, prop)
`define PFM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/pfm_pkg.sv =====
// Types, codes and constants of the pulse flow meter.
`default_nettype none

package pfm_pkg;

   localparam int CountWidthDef = 32;

   // Register reset values
   localparam logic [15:0] MinIntervalRst = 16'd1000;
   localparam logic [15:0] PeriodRst      = 16'd1000;
   localparam logic [15:0] CalRst         = 16'd1920;
   localparam logic [31:0] CommitDeltaRst = 32'd450;
   localparam logic [31:0] IdleDelayRst   = 32'd5000;

   localparam logic [31:0] StopDelayMs = 32'd1200;

   // Reciprocal constants: x / 5 = (x * Div5Magic) >> Div5Shift for x < 2^22,
   // x / 1000 = (x * Div1000Magic) >> Div1000Shift for any 32-bit x.
   localparam logic [19:0] Div5Magic    = 20'd838861;
   localparam int          Div5Shift    = 22;
   localparam logic [28:0] Div1000Magic = 29'd274877907;
   localparam int          Div1000Shift = 38;

   // Quotient bits of the rate divider
   localparam int DivSteps = 16;

   typedef enum logic [2:0] {
      CMD_PULSE         = 3'd0,
      CMD_TICK          = 3'd1,
      CMD_SESSION_RESET = 3'd2,
      CMD_TOTAL_RESET   = 3'd3,
      CMD_LOAD          = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_MIN_INTERVAL = 3'd0,
      CSR_PERIOD       = 3'd1,
      CSR_CAL          = 3'd2,
      CSR_COMMIT_DELTA = 3'd3,
      CSR_IDLE_DELAY   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_PREP,
      S_OVF,
      S_DIV,
      S_SUM,
      S_MUL,
      S_APPLY,
      S_SECS,
      S_EMPTY,
      S_COMMIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] time_us;
      logic [31:0] time_ms;
      logic [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic [15:0] flow_rate_q8;
      logic [31:0] session_pulses;
      logic [31:0] total_pulses;
      logic [31:0] session_seconds;
      logic        flowing;
      logic        pulse_accepted;
      logic        sampled;
      logic        commit_request;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic prep;
      logic ovf;
      logic div_step;
      logic sum;
      logic mul;
      logic apply;
      logic secs;
      logic empty;
      logic commit;
   } ctl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic sample_go;
      logic delta_zero;
      logic ovf;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/pfm_ctrl.sv =====
// Sequencing state machine of the pulse flow meter.
`default_nettype none
`include "pulse_flow_meter_unit_defines.svh"

module pfm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  pfm_pkg::stat_type   status,
   output pfm_pkg::ctl_type    ctl
);
   import pfm_pkg::*;

   localparam int CntW = $clog2(DivSteps);

   state_type         state_ff, state_in;
   logic [CntW-1:0]   div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      ctl        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.decode = 1'b1;
            if (!status.sample_go) begin
               state_in = S_OUT;
            end else if (status.delta_zero) begin
               state_in = S_EMPTY;
            end else begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            ctl.prep = 1'b1;
            state_in = S_OVF;
         end
         S_OVF: begin
            ctl.ovf = 1'b1;
            if (status.ovf) begin
               state_in = S_SUM;
            end else begin
               div_cnt_in = CntW'(DivSteps - 1);
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = S_SUM;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         S_SUM: begin
            ctl.sum  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            ctl.mul  = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            ctl.apply = 1'b1;
            state_in  = S_SECS;
         end
         S_SECS: begin
            ctl.secs = 1'b1;
            state_in = S_COMMIT;
         end
         S_EMPTY: begin
            ctl.empty = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `PFM_ASSERT(a_div_ends, (state_ff == S_DIV && div_cnt_ff == '0) |=> (state_ff == S_SUM))
   `PFM_ASSERT(a_accept_decodes, (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
   `PFM_ASSERT(a_out_entry, $rose(state_ff == S_OUT) |-> ($past(state_ff) == S_DECODE || $past(state_ff) == S_COMMIT))

endmodule

`default_nettype wire

// ===== rtl/pfm_datapath.sv =====
// Registers, rate divider and state update of the pulse flow meter.
`default_nettype none
`include "pulse_flow_meter_unit_defines.svh"

module pfm_datapath #(
   parameter int COUNT_WIDTH = pfm_pkg::CountWidthDef
) (
   input  wire                 clock,
   input  wire                 reset,
   input  pfm_pkg::req_type    req_data,
   input  wire                 csr_write,
   input  wire [2:0]           csr_index,
   input  wire [31:0]          csr_data,
   input  pfm_pkg::ctl_type    ctl,
   output pfm_pkg::stat_type   status,
   output pfm_pkg::rsp_type    rsp_data
);
   import pfm_pkg::*;

   localparam int ProdW = COUNT_WIDTH + 7;           // delta * 125
   localparam int NumW  = ProdW + 19;                // delta * 125 * 2^19
   localparam int DenW  = 48;
   localparam int RemW  = DenW + DivSteps;
   localparam int OvfW  = (NumW > RemW) ? NumW : RemW;
   localparam int CmpW  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int SumW  = 19;
   localparam int MulW  = SumW + 20;
   localparam int SecW  = 32 + 29;

   // Configuration
   logic [15:0] min_int_ff, period_ff, cal_ff;
   logic [31:0] cdelta_ff, idle_delay_ff;

   // Block state
   logic [COUNT_WIDTH-1:0] pulse_count_ff, pulse_count_in;
   logic [COUNT_WIDTH-1:0] last_sample_count_ff, last_sample_count_in;
   logic [COUNT_WIDTH-1:0] session_count_ff, session_count_in;
   logic [COUNT_WIDTH-1:0] total_count_ff, total_count_in;
   logic [COUNT_WIDTH-1:0] committed_count_ff, committed_count_in;
   logic [31:0] last_pulse_time_ff, last_pulse_time_in;
   logic [31:0] last_sample_time_ff, last_sample_time_in;
   logic [31:0] stop_time_ff, stop_time_in;
   logic [31:0] session_start_ff, session_start_in;
   logic [31:0] session_secs_ff, session_secs_in;
   logic [15:0] smoothed_ff, smoothed_in;
   logic        stop_pending_ff, stop_pending_in;
   logic        active_ff, active_in;
   logic        dirty_ff, dirty_in;
   logic        flag_acc_ff, flag_acc_in;
   logic        flag_smp_ff, flag_smp_in;
   logic        flag_cmt_ff, flag_cmt_in;

   // Work registers
   req_type                req_ff, req_in;
   logic [31:0]            dt_ff, dt_in;
   logic [COUNT_WIDTH-1:0] delta_ff, delta_in;
   logic [NumW-1:0]        num_ff, num_in;
   logic [DenW-1:0]        den_ff, den_in;
   logic [RemW-1:0]        rem_ff, rem_in;
   logic [RemW-1:0]        dsh_ff, dsh_in;
   logic [15:0]            quo_ff, quo_in;
   logic [SumW-1:0]        sum_ff, sum_in;
   logic [MulW-1:0]        mul_ff, mul_in;
   logic [SecW-1:0]        secs_prod_ff, secs_prod_in;

   // Combinational terms
   logic [31:0]            dt_w, dt_eff, pulse_gap, stop_gap, secs_diff;
   logic [15:0]            cal_eff;
   logic [COUNT_WIDTH-1:0] delta_w, pending_w;
   logic [ProdW-1:0]       prod125;
   logic                   ovf_w, commit_delta_hit, commit_idle_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_int_ff    <= MinIntervalRst;
         period_ff     <= PeriodRst;
         cal_ff        <= CalRst;
         cdelta_ff     <= CommitDeltaRst;
         idle_delay_ff <= IdleDelayRst;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MIN_INTERVAL: min_int_ff    <= csr_data[15:0];
            CSR_PERIOD:       period_ff     <= csr_data[15:0];
            CSR_CAL:          cal_ff        <= csr_data[15:0];
            CSR_COMMIT_DELTA: cdelta_ff     <= csr_data;
            CSR_IDLE_DELAY:   idle_delay_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign dt_w      = req_ff.time_ms - last_sample_time_ff;
   assign delta_w   = pulse_count_ff - last_sample_count_ff;
   assign pulse_gap = req_ff.time_us - last_pulse_time_ff;
   assign stop_gap  = req_ff.time_ms - stop_time_ff;
   assign pending_w = total_count_ff - committed_count_ff;
   assign dt_eff    = (dt_ff == '0) ? 32'd1 : dt_ff;
   assign cal_eff   = (cal_ff == '0) ? 16'd1 : cal_ff;
   assign prod125   = (ProdW'(delta_ff) << 7) - (ProdW'(delta_ff) << 1) - ProdW'(delta_ff);
   assign ovf_w     = OvfW'(num_ff) >= OvfW'({den_ff, {DivSteps{1'b0}}});
   assign secs_diff = active_ff ? (req_ff.time_ms - session_start_ff) : 32'd0;
   assign commit_delta_hit = CmpW'(pending_w) >= CmpW'(cdelta_ff);
   assign commit_idle_hit  = dirty_ff && !active_ff && stop_pending_ff &&
                             (stop_gap >= idle_delay_ff);

   assign status.sample_go  = (req_ff.cmd == CMD_TICK) && (dt_w >= {16'd0, period_ff});
   assign status.delta_zero = (delta_w == '0);
   assign status.ovf        = ovf_w;

   always_comb begin
      pulse_count_in       = pulse_count_ff;
      last_sample_count_in = last_sample_count_ff;
      session_count_in     = session_count_ff;
      total_count_in       = total_count_ff;
      committed_count_in   = committed_count_ff;
      last_pulse_time_in   = last_pulse_time_ff;
      last_sample_time_in  = last_sample_time_ff;
      stop_time_in         = stop_time_ff;
      session_start_in     = session_start_ff;
      session_secs_in      = session_secs_ff;
      smoothed_in          = smoothed_ff;
      stop_pending_in      = stop_pending_ff;
      active_in            = active_ff;
      dirty_in             = dirty_ff;
      flag_acc_in          = flag_acc_ff;
      flag_smp_in          = flag_smp_ff;
      flag_cmt_in          = flag_cmt_ff;
      req_in               = req_ff;
      dt_in                = dt_ff;
      delta_in             = delta_ff;
      num_in               = num_ff;
      den_in               = den_ff;
      rem_in               = rem_ff;
      dsh_in               = dsh_ff;
      quo_in               = quo_ff;
      sum_in               = sum_ff;
      mul_in               = mul_ff;
      secs_prod_in         = secs_prod_ff;

      if (ctl.capture) begin
         req_in      = req_data;
         flag_acc_in = 1'b0;
         flag_smp_in = 1'b0;
         flag_cmt_in = 1'b0;
      end

      if (ctl.decode) begin
         case (req_ff.cmd)
            CMD_PULSE: begin
               if (pulse_gap >= {16'd0, min_int_ff}) begin
                  pulse_count_in     = pulse_count_ff + 1'b1;
                  last_pulse_time_in = req_ff.time_us;
                  flag_acc_in        = 1'b1;
               end
            end
            CMD_TICK: begin
               if (status.sample_go) begin
                  flag_smp_in          = 1'b1;
                  last_sample_time_in  = req_ff.time_ms;
                  last_sample_count_in = pulse_count_ff;
                  dt_in                = dt_w;
                  delta_in             = delta_w;
               end
            end
            CMD_SESSION_RESET: begin
               session_count_in = '0;
               session_secs_in  = '0;
               session_start_in = req_ff.time_ms;
            end
            CMD_TOTAL_RESET: begin
               total_count_in     = '0;
               committed_count_in = '0;
               dirty_in           = 1'b0;
               flag_cmt_in        = 1'b1;
            end
            CMD_LOAD: begin
               total_count_in     = COUNT_WIDTH'(req_ff.load_value);
               committed_count_in = COUNT_WIDTH'(req_ff.load_value);
            end
            default: ;
         endcase
      end

      if (ctl.prep) begin
         num_in = {prod125, 19'd0};
         den_in = {16'd0, dt_eff} * {32'd0, cal_eff};
      end

      // Saturate when the quotient cannot fit 16 bits, else seed the divider
      if (ctl.ovf) begin
         if (ovf_w) begin
            quo_in = 16'hFFFF;
         end else begin
            rem_in = RemW'(num_ff);
            dsh_in = {1'b0, den_ff, {(DivSteps - 1){1'b0}}};
            quo_in = '0;
         end
      end

      if (ctl.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            quo_in = {quo_ff[14:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
      end

      // 2*old + 3*raw + 2, then divide by five
      if (ctl.sum) begin
         sum_in = SumW'({smoothed_ff, 1'b0}) + SumW'({quo_ff, 1'b0}) + SumW'(quo_ff) + SumW'(2);
      end

      if (ctl.mul) begin
         mul_in = MulW'(sum_ff) * MulW'(Div5Magic);
      end

      if (ctl.apply) begin
         smoothed_in = mul_ff[Div5Shift +: 16];
         if (!active_ff) begin
            session_start_in = req_ff.time_ms;
         end
         active_in        = 1'b1;
         stop_pending_in  = 1'b0;
         session_count_in = session_count_ff + delta_ff;
         total_count_in   = total_count_ff + delta_ff;
         dirty_in         = 1'b1;
         secs_prod_in     = SecW'(secs_diff) * SecW'(Div1000Magic);
      end

      if (ctl.secs) begin
         session_secs_in = 32'(secs_prod_ff[SecW-1:Div1000Shift]);
      end

      if (ctl.empty) begin
         smoothed_in = '0;
         if (active_ff) begin
            if (!stop_pending_ff) begin
               stop_pending_in = 1'b1;
               stop_time_in    = req_ff.time_ms;
            end else if (stop_gap > StopDelayMs) begin
               active_in       = 1'b0;
               session_secs_in = '0;
            end
         end
      end

      if (ctl.commit) begin
         if (commit_delta_hit || commit_idle_hit) begin
            committed_count_in = total_count_ff;
            dirty_in           = 1'b0;
            flag_cmt_in        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff       <= '0;
         last_sample_count_ff <= '0;
         session_count_ff     <= '0;
         total_count_ff       <= '0;
         committed_count_ff   <= '0;
         last_pulse_time_ff   <= '0;
         last_sample_time_ff  <= '0;
         stop_time_ff         <= '0;
         session_start_ff     <= '0;
         session_secs_ff      <= '0;
         smoothed_ff          <= '0;
         stop_pending_ff      <= 1'b0;
         active_ff            <= 1'b0;
         dirty_ff             <= 1'b0;
         flag_acc_ff          <= 1'b0;
         flag_smp_ff          <= 1'b0;
         flag_cmt_ff          <= 1'b0;
      end else begin
         pulse_count_ff       <= pulse_count_in;
         last_sample_count_ff <= last_sample_count_in;
         session_count_ff     <= session_count_in;
         total_count_ff       <= total_count_in;
         committed_count_ff   <= committed_count_in;
         last_pulse_time_ff   <= last_pulse_time_in;
         last_sample_time_ff  <= last_sample_time_in;
         stop_time_ff         <= stop_time_in;
         session_start_ff     <= session_start_in;
         session_secs_ff      <= session_secs_in;
         smoothed_ff          <= smoothed_in;
         stop_pending_ff      <= stop_pending_in;
         active_ff            <= active_in;
         dirty_ff             <= dirty_in;
         flag_acc_ff          <= flag_acc_in;
         flag_smp_ff          <= flag_smp_in;
         flag_cmt_ff          <= flag_cmt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      dt_ff        <= dt_in;
      delta_ff     <= delta_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      sum_ff       <= sum_in;
      mul_ff       <= mul_in;
      secs_prod_ff <= secs_prod_in;
   end

   assign rsp_data.flow_rate_q8    = smoothed_ff;
   assign rsp_data.session_pulses  = 32'(session_count_ff);
   assign rsp_data.total_pulses    = 32'(total_count_ff);
   assign rsp_data.session_seconds = session_secs_ff;
   assign rsp_data.flowing         = active_ff;
   assign rsp_data.pulse_accepted  = flag_acc_ff;
   assign rsp_data.sampled         = flag_smp_ff;
   assign rsp_data.commit_request  = flag_cmt_ff;

   `PFM_ASSERT(a_commit_matches, flag_cmt_ff |-> (committed_count_ff == total_count_ff))
   `PFM_ASSERT(a_pulse_or_sample, !(flag_acc_ff && flag_smp_ff))

endmodule

`default_nettype wire

// ===== rtl/pulse_flow_meter_unit.sv =====
// Top level of the pulse flow meter: controller plus datapath.
`default_nettype none

// Pulse flow meter for a Hall sensor. One request is taken at a time; req_stall
// stays high from acceptance until the response has been taken. A pulse edge,
// session reset, total reset, total load, unused command or a tick that comes
// before the sample period goes from decode straight to the response; a sample
// tick that finds no new pulses passes through the empty and commit states, and a
// tick that measures a rate runs prep, the overflow check, the 16-step restoring
// divider that forms pulses * 65536000 / (dt_ms * cal_factor_q8), sum, multiply,
// apply, seconds and commit; the divider is skipped when the rate saturates. After
// the response the block returns to idle, where the next request is taken. Register
// writes take effect at the edge where csr_write is high and belong between requests.
// Counts wrap at COUNT_WIDTH bits; the 32-bit count outputs show their low bits.

module pulse_flow_meter_unit #(
   parameter int COUNT_WIDTH = pfm_pkg::CountWidthDef
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  pfm_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pfm_pkg::rsp_type    rsp_data,
   input  wire                 csr_write,
   input  wire [2:0]           csr_index,
   input  wire [31:0]          csr_data
);
   import pfm_pkg::*;

   ctl_type  ctl;
   stat_type status;

   pfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .ctl       (ctl)
   );

   pfm_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
